@@ sv/dcsa_pkg.sv @@
// dcsa_pkg.sv: shared types and constants for the drive command source arbiter
`default_nettype none

package dcsa_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIO_TMO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_TMO = 2'd2;

  localparam logic [14:0] DEADBAND_RST    = 15'd16;
  localparam logic [7:0]  RADIO_TMO_RST   = 8'd5;
  localparam logic [7:0]  NETWORK_TMO_RST = 8'd5;

  localparam logic [7:0] IDLE_MAX = 8'd255;

  localparam logic SRC_RADIO   = 1'b0;
  localparam logic SRC_NETWORK = 1'b1;

  localparam logic [1:0] SUP_NONE = 2'd0;

  localparam logic signed [15:0] Q14_MIN = 16'sh8000;
  localparam logic signed [15:0] Q14_MAX = 16'sh7fff;

  typedef struct packed {
    logic               radio_present;
    logic signed [15:0] radio_steer;
    logic signed [15:0] radio_throttle;
    logic signed [15:0] radio_stop_switch;
    logic signed [15:0] radio_mode_switch;
    logic               net_present;
    logic signed [15:0] net_linear;
    logic signed [15:0] net_angular;
    logic               sup_present;
    logic [1:0]         sup_value;
  } dcsa_in_t;

  typedef struct packed {
    logic               motion_valid;
    logic signed [15:0] motion_linear;
    logic signed [15:0] motion_angular;
    logic               radio_connected;
    logic               stop_active;
    logic               source_mode;
    logic [1:0]         supervisor_mode;
  } dcsa_out_t;

  typedef struct packed {
    logic     valid;
    dcsa_in_t data;
  } dcsa_stage_t;

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] x);
    neg_sat16 = (x == Q14_MIN) ? Q14_MAX : -x;
  endfunction

endpackage

`default_nettype wire

@@ sv/dcsa_if.sv @@
// dcsa_if.sv: request channels for ticks, results and register writes
`default_nettype none

interface dcsa_in_if;
  import dcsa_pkg::*;
  logic     valid;
  logic     ready;
  dcsa_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcsa_out_if;
  import dcsa_pkg::*;
  logic      valid;
  logic      ready;
  dcsa_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dcsa_cfg_if;
  import dcsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ sv/drive_command_source_arbiter_core.sv @@
// drive_command_source_arbiter_core.sv: top level of the drive command source arbiter
//
// usage
//   in_chan  : one control tick per request (radio, network and supervisor fields)
//   out_chan : one result per tick (motion command and robot status)
//   cfg_chan : register writes, index 0 deadband, 1 radio timeout, 2 network timeout;
//              always ready, write only while no tick is in flight
//   path     : an accepted tick is held in the input register, then its result in the result register
//   throughput: one tick per cycle while out_chan is ready; the core updates its state as each tick moves on
//   reset    : rst_n low clears both stages, link state, counters and held commands;
//              registers return to deadband 16 and timeouts of 5, source is network
//   stall    : while out_chan is not ready the result register holds its request,
//              one more tick waits in the input register, then in_chan ready drops
`default_nettype none

module drive_command_source_arbiter_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dcsa_in_if.sink     in_chan,
  dcsa_out_if.source  out_chan,
  dcsa_cfg_if.sink    cfg_chan
);
  import dcsa_pkg::*;

  dcsa_stage_t stage;
  dcsa_out_t   result;
  logic        advance;

  dcsa_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_data  (in_chan.data),
    .in_ready (in_chan.ready),
    .advance  (advance),
    .stage    (stage)
  );

  dcsa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_wdata (cfg_chan.wdata),
    .cfg_ready (cfg_chan.ready),
    .stage     (stage),
    .advance   (advance),
    .result    (result)
  );

  dcsa_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .load_req  (stage.valid),
    .advance   (advance),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data),
    .out_ready (out_chan.ready)
  );

endmodule

`default_nettype wire

@@ sv/dcsa_in_reg.sv @@
// dcsa_in_reg.sv: input register stage for control tick requests
`default_nettype none

module dcsa_in_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire dcsa_pkg::dcsa_in_t   in_data,
  output logic                      in_ready,
  input  wire logic                 advance,
  output dcsa_pkg::dcsa_stage_t     stage
);
  import dcsa_pkg::*;

  logic     valid_r, valid_nxt;
  dcsa_in_t data_r;
  logic     load;

  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

`default_nettype wire

@@ sv/dcsa_core.sv @@
// dcsa_core.sv: source selection, link timeouts, stop and supervisor handling and config registers
`default_nettype none

module dcsa_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [dcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dcsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                    cfg_ready,
  input  wire dcsa_pkg::dcsa_stage_t              stage,
  input  wire logic                               advance,
  output dcsa_pkg::dcsa_out_t                     result
);
  import dcsa_pkg::*;

  logic [14:0] deadband_r;
  logic [7:0]  radio_tmo_r;
  logic [7:0]  net_tmo_r;

  logic [7:0]         radio_idle_r, radio_idle_nxt;
  logic [7:0]         net_idle_r, net_idle_nxt;
  logic signed [15:0] held_lin_r, held_lin_nxt;
  logic signed [15:0] held_ang_r, held_ang_nxt;
  logic signed [15:0] cur_lin_r, cur_lin_nxt;
  logic signed [15:0] cur_ang_r, cur_ang_nxt;
  logic               alive_r, alive_nxt;
  logic               stop_r, stop_nxt;
  logic               mode_r, mode_nxt;
  logic [1:0]         sup_r, sup_nxt;

  logic signed [16:0] mode_ch;
  logic signed [16:0] db;
  logic               in_band;
  logic               fire;
  dcsa_in_t           d;

  assign cfg_ready = 1'b1;
  assign d         = stage.data;
  assign fire      = stage.valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= DEADBAND_RST;
      radio_tmo_r <= RADIO_TMO_RST;
      net_tmo_r   <= NETWORK_TMO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADBAND:    deadband_r  <= cfg_wdata[14:0];
        CFG_RADIO_TMO:   radio_tmo_r <= cfg_wdata[7:0];
        CFG_NETWORK_TMO: net_tmo_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign mode_ch = {d.radio_mode_switch[15], d.radio_mode_switch};
  assign db      = $signed({2'b00, deadband_r});
  assign in_band = (mode_ch < db) && (mode_ch > -db);

  always_comb begin
    radio_idle_nxt = radio_idle_r;
    net_idle_nxt   = net_idle_r;
    held_lin_nxt   = held_lin_r;
    held_ang_nxt   = held_ang_r;
    cur_lin_nxt    = cur_lin_r;
    cur_ang_nxt    = cur_ang_r;
    alive_nxt      = alive_r;
    stop_nxt       = stop_r;
    mode_nxt       = mode_r;
    sup_nxt        = sup_r;

    // radio link
    if (d.radio_present) begin
      radio_idle_nxt = 8'd0;
      alive_nxt      = 1'b1;
      if (in_band) begin
        mode_nxt    = SRC_RADIO;
        cur_lin_nxt = d.radio_throttle;
        cur_ang_nxt = neg_sat16(d.radio_steer);
      end else begin
        mode_nxt = SRC_NETWORK;
      end
      stop_nxt = d.radio_stop_switch > 16'sd0;
    end else if (radio_idle_r > radio_tmo_r) begin
      alive_nxt = 1'b0;
      stop_nxt  = 1'b0;
      mode_nxt  = SRC_NETWORK;
    end else if (radio_idle_r < IDLE_MAX) begin
      radio_idle_nxt = radio_idle_r + 8'd1;
    end

    // network command hold
    if (mode_nxt == SRC_NETWORK) begin
      if (d.net_present) begin
        held_lin_nxt = d.net_linear;
        held_ang_nxt = d.net_angular;
        net_idle_nxt = 8'd0;
      end else if (net_idle_r > net_tmo_r) begin
        held_lin_nxt = 16'sd0;
        held_ang_nxt = 16'sd0;
      end else if (net_idle_r < IDLE_MAX) begin
        net_idle_nxt = net_idle_r + 8'd1;
      end
      cur_lin_nxt = held_lin_nxt;
      cur_ang_nxt = held_ang_nxt;
    end

    if (d.sup_present) begin
      sup_nxt = d.sup_value;
    end

    if (sup_nxt == SUP_NONE && stop_nxt) begin
      cur_lin_nxt = 16'sd0;
      cur_ang_nxt = 16'sd0;
    end

    result.motion_valid    = (sup_nxt == SUP_NONE);
    result.motion_linear   = (sup_nxt == SUP_NONE) ? cur_lin_nxt : 16'sd0;
    result.motion_angular  = (sup_nxt == SUP_NONE) ? cur_ang_nxt : 16'sd0;
    result.radio_connected = alive_nxt;
    result.stop_active     = stop_nxt;
    result.source_mode     = mode_nxt;
    result.supervisor_mode = sup_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_idle_r <= 8'd0;
      net_idle_r   <= 8'd0;
      held_lin_r   <= 16'sd0;
      held_ang_r   <= 16'sd0;
      cur_lin_r    <= 16'sd0;
      cur_ang_r    <= 16'sd0;
      alive_r      <= 1'b0;
      stop_r       <= 1'b0;
      mode_r       <= SRC_NETWORK;
      sup_r        <= SUP_NONE;
    end else if (fire) begin
      radio_idle_r <= radio_idle_nxt;
      net_idle_r   <= net_idle_nxt;
      held_lin_r   <= held_lin_nxt;
      held_ang_r   <= held_ang_nxt;
      cur_lin_r    <= cur_lin_nxt;
      cur_ang_r    <= cur_ang_nxt;
      alive_r      <= alive_nxt;
      stop_r       <= stop_nxt;
      mode_r       <= mode_nxt;
      sup_r        <= sup_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/dcsa_out_reg.sv @@
// dcsa_out_reg.sv: result register in front of the result channel
`default_nettype none

module dcsa_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dcsa_pkg::dcsa_out_t  result,
  input  wire logic                 load_req,
  output logic                      advance,
  output logic                      out_valid,
  output dcsa_pkg::dcsa_out_t       out_data,
  input  wire logic                 out_ready
);
  import dcsa_pkg::*;

  logic      valid_r, valid_nxt;
  dcsa_out_t data_r;
  logic      load;

  assign advance = !valid_r || out_ready;
  assign load    = load_req && advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ sv/dcsa_checker.sv @@
// dcsa_checker.sv: port-level assertions for the drive command source arbiter
`default_nettype none

module dcsa_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dcsa_pkg::dcsa_out_t out_data
);
  import dcsa_pkg::*;

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // supervised results carry no motion
  a_sup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.motion_valid |->
      out_data.motion_linear == 16'sd0 && out_data.motion_angular == 16'sd0)
    else $error("motion nonzero in supervised mode");

  // stop forces a zero motion command
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stop_active && out_data.motion_valid |->
      out_data.motion_linear == 16'sd0 && out_data.motion_angular == 16'sd0)
    else $error("motion nonzero under stop");

  // stop and radio source need a live radio link
  a_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stop_active || out_data.source_mode == SRC_RADIO) |->
      out_data.radio_connected)
    else $error("radio state without link");

endmodule

bind drive_command_source_arbiter_core dcsa_checker u_dcsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

`default_nettype wire
